>>> design/pms_pkg.sv
// ----------------------------------------------------------------------------
// pms_pkg: shared types and codes of the periodic message scheduler
// Table entry layout, function codes, status codes and parameter defaults.
// ----------------------------------------------------------------------------
package pms_pkg;

  // Parameter defaults
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int MAILBOXES_DEF   = 3;

  // Field widths fixed by the interface
  localparam int ID_W     = 29;
  localparam int LEN_W    = 4;
  localparam int PERIOD_W = 16;
  localparam int TIME_W   = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int FREE_W   = 2;
  localparam int STD_ID_W = 11;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_PERIOD = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_STOPPED     = 3'd5;

  // Result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_TX     = 1'b1;

  // One table entry as held in the entry memory
  typedef struct packed {
    logic [ID_W-1:0]     ident;
    logic                is_ext;
    logic                rtr;
    logic [LEN_W-1:0]    len;
    logic [PERIOD_W-1:0] period;
    logic [TIME_W-1:0]   last_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> design/pms_ram.sv
// ----------------------------------------------------------------------------
// pms_ram: generic single-write, single-read memory
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module pms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one word, read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/periodic_message_scheduler.sv
// ----------------------------------------------------------------------------
// periodic_message_scheduler: table of periodic transmit entries
// Add, remove and tick commands over a compact entry table in one memory.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. For a command that
// visits the table, busy then stays high until the cycle in which its final
// result appears. Results come out one per beat, each marked by out_valid for
// one cycle, and the receiver cannot stall them; out_last flags the final
// result of a command. The entry memory has one read port with a registered
// output, so every entry visit takes a read state and a second state that
// uses the data read. An add searches the entries in use for a duplicate and
// then writes the new entry into the next free slot. A remove searches up to
// the match and then moves each later entry down one slot. A tick walks the
// entries until the end of the table or the first due entry that finds no
// mailbox left. An add rejected for a full table or a zero period, and an
// unused function code, never raise busy.
// ----------------------------------------------------------------------------
module periodic_message_scheduler #(
  parameter int MAX_ENTRIES = pms_pkg::MAX_ENTRIES_DEF,
  parameter int MAILBOXES   = pms_pkg::MAILBOXES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pms_pkg::FUNC_W-1:0]    in_func,
  input  logic [pms_pkg::ID_W-1:0]      in_msg_id,
  input  logic                          in_id_extended,
  input  logic                          in_remote_frame,
  input  logic [pms_pkg::LEN_W-1:0]     in_data_length,
  input  logic [pms_pkg::PERIOD_W-1:0]  in_period_ms,
  input  logic [pms_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [pms_pkg::FREE_W-1:0]    in_free_mailboxes,
  output logic                          out_valid,
  output logic                          out_kind,
  output logic [pms_pkg::STATUS_W-1:0]  out_status,
  output logic [pms_pkg::ID_W-1:0]      out_tx_id,
  output logic                          out_tx_extended,
  output logic                          out_tx_remote,
  output logic [pms_pkg::LEN_W-1:0]     out_tx_length,
  output logic [pms_pkg::SLOT_W-1:0]    out_tx_slot,
  output logic                          out_last
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int LW = $clog2(MAILBOXES + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_SRCH_RD  = 3'd1;
  localparam logic [2:0] S_SRCH_CMP = 3'd2;
  localparam logic [2:0] S_SHIFT_RD = 3'd3;
  localparam logic [2:0] S_SHIFT_WR = 3'd4;
  localparam logic [2:0] S_WALK_RD  = 3'd5;
  localparam logic [2:0] S_WALK_EV  = 3'd6;

  logic [2:0]                     state_r, state_nxt;
  logic [CW-1:0]                  idx_r, idx_nxt;
  logic [CW-1:0]                  count_r, count_nxt;
  logic [LW-1:0]                  left_r, left_nxt;
  logic [pms_pkg::FUNC_W-1:0]     func_r, func_nxt;
  logic [pms_pkg::ID_W-1:0]       key_r, key_nxt;
  logic                           ext_r, ext_nxt;
  logic                           rtr_r, rtr_nxt;
  logic [pms_pkg::LEN_W-1:0]      len_r, len_nxt;
  logic [pms_pkg::PERIOD_W-1:0]   period_r, period_nxt;
  logic [pms_pkg::TIME_W-1:0]     now_r, now_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic                           out_kind_r, out_kind_nxt;
  logic [pms_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [pms_pkg::ID_W-1:0]       out_id_r, out_id_nxt;
  logic                           out_ext_r, out_ext_nxt;
  logic                           out_rtr_r, out_rtr_nxt;
  logic [pms_pkg::LEN_W-1:0]      out_len_r, out_len_nxt;
  logic [pms_pkg::SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  pms_pkg::entry_t                ram_wdata;
  logic [AW-1:0]                  ram_raddr;
  pms_pkg::entry_t                rd_entry;
  logic [pms_pkg::ENTRY_W-1:0]    ram_rdata;

  logic [CW-1:0]                  idx_inc;
  logic [pms_pkg::TIME_W-1:0]     due_at;
  logic                           due;
  logic                           id_match;
  logic [LW-1:0]                  left_init;
  logic [pms_pkg::ID_W-1:0]       add_key;

  assign rd_entry = pms_pkg::entry_t'(ram_rdata);
  assign idx_inc  = idx_r + CW'(1);

  // Shared compare unit: due test and identifier match on the entry just read
  assign due_at   = rd_entry.last_time + pms_pkg::TIME_W'(rd_entry.period);
  assign due      = now_r > due_at;
  assign id_match = rd_entry.ident == key_r;

  // Usable mailboxes, capped at the mailbox count
  assign left_init = (int'(in_free_mailboxes) > MAILBOXES) ? LW'(MAILBOXES)
                                                          : LW'(in_free_mailboxes);

  // Standard identifiers keep only their low bits
  assign add_key = in_id_extended ? in_msg_id
                 : {{(pms_pkg::ID_W-pms_pkg::STD_ID_W){1'b0}},
                    in_msg_id[pms_pkg::STD_ID_W-1:0]};

  // Read address: the shift pass reads one slot ahead
  always_comb begin
    if (state_r == S_SHIFT_RD) begin
      ram_raddr = AW'(idx_inc);
    end else begin
      ram_raddr = AW'(idx_r);
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    left_nxt       = left_r;
    func_nxt       = func_r;
    key_nxt        = key_r;
    ext_nxt        = ext_r;
    rtr_nxt        = rtr_r;
    len_nxt        = len_r;
    period_nxt     = period_r;
    now_nxt        = now_r;

    out_valid_nxt  = 1'b0;
    out_kind_nxt   = pms_pkg::KIND_STATUS;
    out_status_nxt = pms_pkg::ST_OK;
    out_id_nxt     = '0;
    out_ext_nxt    = 1'b0;
    out_rtr_nxt    = 1'b0;
    out_len_nxt    = '0;
    out_slot_nxt   = '0;
    out_last_nxt   = 1'b1;

    ram_we         = 1'b0;
    ram_waddr      = AW'(idx_r);
    ram_wdata      = rd_entry;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          func_nxt   = in_func;
          ext_nxt    = in_id_extended;
          rtr_nxt    = in_remote_frame;
          len_nxt    = in_data_length;
          period_nxt = in_period_ms;
          now_nxt    = in_now_ms;
          left_nxt   = left_init;
          idx_nxt    = '0;
          unique case (in_func)
            pms_pkg::FUNC_ADD: begin
              key_nxt = add_key;
              priority if (count_r >= CW'(MAX_ENTRIES)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pms_pkg::ST_FULL;
              end else if (in_period_ms == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = pms_pkg::ST_ZERO_PERIOD;
              end else begin
                state_nxt = S_SRCH_RD;
              end
            end
            pms_pkg::FUNC_REMOVE: begin
              key_nxt   = in_msg_id;
              state_nxt = S_SRCH_RD;
            end
            pms_pkg::FUNC_TICK: begin
              state_nxt = S_WALK_RD;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      // Search: read slot, or finish when all slots in use are checked
      S_SRCH_RD: begin
        if (idx_r == count_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (func_r == pms_pkg::FUNC_ADD) begin
            ram_we              = 1'b1;
            ram_waddr           = AW'(count_r);
            ram_wdata.ident     = key_r;
            ram_wdata.is_ext    = ext_r;
            ram_wdata.rtr       = rtr_r;
            ram_wdata.len       = len_r;
            ram_wdata.period    = period_r;
            ram_wdata.last_time = now_r;
            count_nxt           = count_r + CW'(1);
          end else begin
            out_status_nxt = pms_pkg::ST_NOT_FOUND;
          end
        end else begin
          state_nxt = S_SRCH_CMP;
        end
      end

      S_SRCH_CMP: begin
        if (id_match) begin
          if (func_r == pms_pkg::FUNC_ADD) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pms_pkg::ST_DUPLICATE;
            state_nxt      = S_IDLE;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_SRCH_RD;
        end
      end

      // Shift later entries down, one slot per pass
      S_SHIFT_RD: begin
        if (idx_inc >= count_r) begin
          count_nxt     = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(idx_r);
        idx_nxt   = idx_inc;
        state_nxt = S_SHIFT_RD;
      end

      // Tick walk: read slot, or close with status when done
      S_WALK_RD: begin
        if (idx_r == count_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_WALK_EV;
        end
      end

      S_WALK_EV: begin
        if (due) begin
          if (left_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pms_pkg::ST_STOPPED;
            state_nxt      = S_IDLE;
          end else begin
            out_valid_nxt       = 1'b1;
            out_kind_nxt        = pms_pkg::KIND_TX;
            out_id_nxt          = rd_entry.ident;
            out_ext_nxt         = rd_entry.is_ext;
            out_rtr_nxt         = rd_entry.rtr;
            out_len_nxt         = rd_entry.len;
            out_slot_nxt        = pms_pkg::SLOT_W'(idx_r);
            out_last_nxt        = 1'b0;
            ram_we              = 1'b1;
            ram_waddr           = AW'(idx_r);
            ram_wdata.last_time = now_r;
            left_nxt            = left_r - LW'(1);
            idx_nxt             = idx_inc;
            state_nxt           = S_WALK_RD;
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = S_WALK_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Command and result payload
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    left_r       <= left_nxt;
    func_r       <= func_nxt;
    key_r        <= key_nxt;
    ext_r        <= ext_nxt;
    rtr_r        <= rtr_nxt;
    len_r        <= len_nxt;
    period_r     <= period_nxt;
    now_r        <= now_nxt;
    out_kind_r   <= out_kind_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_ext_r    <= out_ext_nxt;
    out_rtr_r    <= out_rtr_nxt;
    out_len_r    <= out_len_nxt;
    out_slot_r   <= out_slot_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Entry table
  pms_ram #(
    .WIDTH (pms_pkg::ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy            = state_r != S_IDLE;
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_tx_id       = out_id_r;
  assign out_tx_extended = out_ext_r;
  assign out_tx_remote   = out_rtr_r;
  assign out_tx_length   = out_len_r;
  assign out_tx_slot     = out_slot_r;
  assign out_last        = out_last_r;

endmodule

>>> verif/periodic_message_scheduler_test.sv
// ----------------------------------------------------------------------------
// periodic_message_scheduler_test: self-checking bench of the entry scheduler
// Runs a stimulus table and then random add, remove and tick traffic. A shadow
// entry table predicts every result beat, which is checked field by field.
// ----------------------------------------------------------------------------
module periodic_message_scheduler_test;

  localparam int MAX_ENTRIES  = pms_pkg::MAX_ENTRIES_DEF;
  localparam int MAILBOX_CAP  = pms_pkg::MAILBOXES_DEF;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_ITEMS   = 80;
  localparam int DRAIN_CYCLES = 60;
  localparam int QUIET_LIMIT  = 1000;

  // Function code that the block ignores apart from one status beat
  localparam logic [pms_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // One command beat as driven on the in_ ports
  typedef struct packed {
    logic [pms_pkg::FUNC_W-1:0]   func;
    logic [pms_pkg::ID_W-1:0]     msg_id;
    logic                         ext;
    logic                         rtr;
    logic [pms_pkg::LEN_W-1:0]    length;
    logic [pms_pkg::PERIOD_W-1:0] period;
    logic [pms_pkg::TIME_W-1:0]   now;
    logic [pms_pkg::FREE_W-1:0]   free_mb;
  } sched_cmd_t;

  // One result beat as seen on the out_ ports
  typedef struct packed {
    logic                         kind;
    logic [pms_pkg::STATUS_W-1:0] status;
    logic [pms_pkg::ID_W-1:0]     tx_id;
    logic                         tx_ext;
    logic                         tx_rtr;
    logic [pms_pkg::LEN_W-1:0]    tx_len;
    logic [pms_pkg::SLOT_W-1:0]   tx_slot;
    logic                         last;
  } sched_beat_t;

  // Stimulus row: a command and, where obvious, its single status typed in
  typedef struct packed {
    sched_cmd_t                   cmd;
    logic                         typed;
    logic [pms_pkg::STATUS_W-1:0] code;
  } stim_row_t;

  localparam int CMD_W = $bits(sched_cmd_t);

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [pms_pkg::FUNC_W-1:0]    in_func;
  logic [pms_pkg::ID_W-1:0]      in_msg_id;
  logic                          in_id_extended;
  logic                          in_remote_frame;
  logic [pms_pkg::LEN_W-1:0]     in_data_length;
  logic [pms_pkg::PERIOD_W-1:0]  in_period_ms;
  logic [pms_pkg::TIME_W-1:0]    in_now_ms;
  logic [pms_pkg::FREE_W-1:0]    in_free_mailboxes;
  logic                          out_valid;
  logic                          out_kind;
  logic [pms_pkg::STATUS_W-1:0]  out_status;
  logic [pms_pkg::ID_W-1:0]      out_tx_id;
  logic                          out_tx_extended;
  logic                          out_tx_remote;
  logic [pms_pkg::LEN_W-1:0]     out_tx_length;
  logic [pms_pkg::SLOT_W-1:0]    out_tx_slot;
  logic                          out_last;

  sched_cmd_t                    drive_cmd;
  logic                          drive_typed;
  logic [pms_pkg::STATUS_W-1:0]  drive_code;

  // Shadow of the entry table and the beats still owed by the block
  pms_pkg::entry_t               shadow_entries [MAX_ENTRIES];
  int                            shadow_count;
  sched_beat_t                   outstanding_results [$];
  logic [pms_pkg::TIME_W-1:0]    clock_ms;
  int                            fail_count;
  int                            quiet_cycles;

  stim_row_t directed_rows [18] = '{
    '{'{pms_pkg::FUNC_TICK,   29'd0,        1'b0, 1'b0, 4'd0,  16'd0,    32'd0,        2'd3},
      1'b1, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_REMOVE, 29'd5,        1'b0, 1'b0, 4'd0,  16'd0,    32'd0,        2'd0},
      1'b1, pms_pkg::ST_NOT_FOUND},
    '{'{pms_pkg::FUNC_ADD,    29'h1FFFFFFF, 1'b1, 1'b1, 4'd8,  16'd0,    32'd0,        2'd0},
      1'b1, pms_pkg::ST_ZERO_PERIOD},
    '{'{pms_pkg::FUNC_ADD,    29'h1FFFFFFF, 1'b1, 1'b1, 4'd8,  16'hFFFF, 32'd0,        2'd0},
      1'b1, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_ADD,    29'h1FFFFFFF, 1'b0, 1'b0, 4'd3,  16'd1,    32'd100,      2'd0},
      1'b1, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_ADD,    29'h7FF,      1'b1, 1'b1, 4'd8,  16'd10,   32'd100,      2'd0},
      1'b1, pms_pkg::ST_DUPLICATE},
    '{'{pms_pkg::FUNC_ADD,    29'd0,        1'b0, 1'b0, 4'd0,  16'd1,    32'hFFFFFFFF, 2'd0},
      1'b1, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_ADD,    29'h15,       1'b0, 1'b1, 4'd15, 16'd2,    32'd50,       2'd0},
      1'b1, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_TICK,   29'd0,        1'b0, 1'b0, 4'd0,  16'd0,    32'd101,      2'd0},
      1'b0, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_TICK,   29'd0,        1'b0, 1'b0, 4'd0,  16'd0,    32'd102,      2'd3},
      1'b0, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_TICK,   29'd0,        1'b0, 1'b0, 4'd0,  16'd0,    32'd102,      2'd1},
      1'b0, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_TICK,   29'd0,        1'b0, 1'b0, 4'd0,  16'd0,    32'hFFFFFFFF, 2'd2},
      1'b0, pms_pkg::ST_OK},
    '{'{FUNC_UNUSED,          29'h1FFFFFFF, 1'b1, 1'b1, 4'd15, 16'hFFFF, 32'hFFFFFFFF, 2'd3},
      1'b1, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_REMOVE, 29'h7FF,      1'b0, 1'b0, 4'd0,  16'd0,    32'd0,        2'd0},
      1'b1, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_REMOVE, 29'h1FFFFFFF, 1'b1, 1'b0, 4'd0,  16'd0,    32'd0,        2'd0},
      1'b1, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_REMOVE, 29'h1FFFFFFF, 1'b1, 1'b0, 4'd0,  16'd0,    32'd0,        2'd0},
      1'b1, pms_pkg::ST_NOT_FOUND},
    '{'{pms_pkg::FUNC_TICK,   29'd0,        1'b0, 1'b0, 4'd0,  16'd0,    32'd0,        2'd3},
      1'b0, pms_pkg::ST_OK},
    '{'{pms_pkg::FUNC_ADD,    29'h1ABCDE,   1'b1, 1'b0, 4'd4,  16'hFFFF, 32'h12345678, 2'd1},
      1'b1, pms_pkg::ST_OK}
  };

  assign in_func           = drive_cmd.func;
  assign in_msg_id         = drive_cmd.msg_id;
  assign in_id_extended    = drive_cmd.ext;
  assign in_remote_frame   = drive_cmd.rtr;
  assign in_data_length    = drive_cmd.length;
  assign in_period_ms      = drive_cmd.period;
  assign in_now_ms         = drive_cmd.now;
  assign in_free_mailboxes = drive_cmd.free_mb;

  periodic_message_scheduler dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_msg_id         (in_msg_id),
    .in_id_extended    (in_id_extended),
    .in_remote_frame   (in_remote_frame),
    .in_data_length    (in_data_length),
    .in_period_ms      (in_period_ms),
    .in_now_ms         (in_now_ms),
    .in_free_mailboxes (in_free_mailboxes),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_status        (out_status),
    .out_tx_id         (out_tx_id),
    .out_tx_extended   (out_tx_extended),
    .out_tx_remote     (out_tx_remote),
    .out_tx_length     (out_tx_length),
    .out_tx_slot       (out_tx_slot),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic sched_beat_t status_only(input logic [pms_pkg::STATUS_W-1:0] code);
    sched_beat_t b;
    b        = '0;
    b.kind   = pms_pkg::KIND_STATUS;
    b.status = code;
    b.last   = 1'b1;
    return b;
  endfunction

  function automatic int find_ident(input logic [pms_pkg::ID_W-1:0] ident);
    for (int i = 0; i < shadow_count; i++) begin
      if (shadow_entries[i].ident == ident) return i;
    end
    return -1;
  endfunction

  // Apply one command to the shadow table and queue the beats it produces
  function automatic void run_table_command(input sched_cmd_t c);
    logic [pms_pkg::ID_W-1:0]     ident;
    logic [pms_pkg::TIME_W-1:0]   due_at;
    logic [pms_pkg::STATUS_W-1:0] st;
    sched_beat_t                  b;
    int                           hit;
    int                           left;
    case (c.func)
      pms_pkg::FUNC_ADD: begin
        ident = c.ext ? c.msg_id : pms_pkg::ID_W'(c.msg_id[pms_pkg::STD_ID_W-1:0]);
        if (shadow_count >= MAX_ENTRIES) st = pms_pkg::ST_FULL;
        else if (c.period == '0) st = pms_pkg::ST_ZERO_PERIOD;
        else if (find_ident(ident) >= 0) st = pms_pkg::ST_DUPLICATE;
        else begin
          shadow_entries[shadow_count] = '{ident, c.ext, c.rtr, c.length, c.period, c.now};
          shadow_count++;
          st = pms_pkg::ST_OK;
        end
        outstanding_results.push_back(status_only(st));
      end
      pms_pkg::FUNC_REMOVE: begin
        hit = find_ident(c.msg_id);
        if (hit < 0) begin
          outstanding_results.push_back(status_only(pms_pkg::ST_NOT_FOUND));
        end else begin
          // close the gap left by the removed entry
          for (int i = hit; i < shadow_count - 1; i++) shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
          outstanding_results.push_back(status_only(pms_pkg::ST_OK));
        end
      end
      pms_pkg::FUNC_TICK: begin
        left = (int'(c.free_mb) > MAILBOX_CAP) ? MAILBOX_CAP : int'(c.free_mb);
        st   = pms_pkg::ST_OK;
        for (int i = 0; i < shadow_count; i++) begin
          due_at = shadow_entries[i].last_time + {16'd0, shadow_entries[i].period};
          if (c.now > due_at) begin
            // stop the walk at the first due entry with no mailbox left
            if (left == 0) begin
              st = pms_pkg::ST_STOPPED;
              break;
            end
            b         = '0;
            b.kind    = pms_pkg::KIND_TX;
            b.tx_id   = shadow_entries[i].ident;
            b.tx_ext  = shadow_entries[i].is_ext;
            b.tx_rtr  = shadow_entries[i].rtr;
            b.tx_len  = shadow_entries[i].len;
            b.tx_slot = pms_pkg::SLOT_W'(i);
            outstanding_results.push_back(b);
            left--;
            shadow_entries[i].last_time = c.now;
          end
        end
        outstanding_results.push_back(status_only(st));
      end
      default: outstanding_results.push_back(status_only(pms_pkg::ST_OK));
    endcase
  endfunction

  // Draw the next random command; filling favors adds, draining favors removes
  function automatic sched_cmd_t next_random_cmd(input bit filling);
    sched_cmd_t c;
    int         r;
    c = '0;
    r = $urandom_range(0, 99);
    if (filling) c.func = (r < 60) ? pms_pkg::FUNC_ADD : (r < 90) ? pms_pkg::FUNC_TICK :
                          (r < 96) ? pms_pkg::FUNC_REMOVE : FUNC_UNUSED;
    else         c.func = (r < 15) ? pms_pkg::FUNC_ADD : (r < 55) ? pms_pkg::FUNC_TICK :
                          (r < 95) ? pms_pkg::FUNC_REMOVE : FUNC_UNUSED;
    c.ext     = 1'($urandom_range(0, 1));
    c.rtr     = 1'($urandom_range(0, 1));
    c.length  = pms_pkg::LEN_W'($urandom_range(0, 15));
    c.free_mb = pms_pkg::FREE_W'($urandom_range(0, 3));
    case ($urandom_range(0, 3))
      0:       c.msg_id = pms_pkg::ID_W'($urandom);
      1:       c.msg_id = {18'($urandom), 11'($urandom_range(0, 47))};
      default: c.msg_id = pms_pkg::ID_W'($urandom_range(0, 47));
    endcase
    case ($urandom_range(0, 9))
      0:       c.period = '0;
      1:       c.period = '1;
      2:       c.period = pms_pkg::PERIOD_W'($urandom);
      default: c.period = pms_pkg::PERIOD_W'($urandom_range(1, 60));
    endcase
    // advance time mostly in small steps, now and then jump or wrap
    case ($urandom_range(0, 19))
      0:       clock_ms = $urandom;
      1:       clock_ms = clock_ms + $urandom_range(0, 70000);
      default: clock_ms = clock_ms + $urandom_range(0, 40);
    endcase
    c.now = ($urandom_range(0, 7) == 0) ? pms_pkg::TIME_W'($urandom) : clock_ms;
    if (c.func == pms_pkg::FUNC_TICK) c.now = clock_ms;
    if (c.func == pms_pkg::FUNC_REMOVE && shadow_count > 0 && $urandom_range(0, 3) != 0)
      c.msg_id = shadow_entries[$urandom_range(0, shadow_count - 1)].ident;
    return c;
  endfunction

  // Present one command beat and hold it until the block takes it
  task automatic issue_cmd(input sched_cmd_t c, input logic typed,
                           input logic [pms_pkg::STATUS_W-1:0] code, input bit allow_idle);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start     <= 1'b0;
      drive_cmd <= sched_cmd_t'(CMD_W'({$urandom, $urandom, $urandom}));
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    start       <= 1'b1;
    drive_cmd   <= c;
    drive_typed <= typed;
    drive_code  <= code;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Stimulus: reset, stimulus table, random traffic, then drain
  initial begin
    bit filling;
    rst_n       <= 1'b0;
    start       <= 1'b0;
    drive_cmd   <= '0;
    drive_typed <= 1'b0;
    drive_code  <= pms_pkg::ST_OK;
    clock_ms     = $urandom;
    filling      = 1'b1;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed_rows[i])
      issue_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].code, 1'b1);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (filling && shadow_count == MAX_ENTRIES && $urandom_range(0, 7) == 0)
        filling = 1'b0;
      else if (!filling && shadow_count == 0 && $urandom_range(0, 3) == 0)
        filling = 1'b1;
      issue_cmd(next_random_cmd(filling), 1'b0, pms_pkg::ST_OK,
                n < RANDOM_ITEMS - CALM_ITEMS);
    end
    start <= 1'b0;
    while (outstanding_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("periodic_message_scheduler test passed");
    end else begin
      $display("periodic_message_scheduler test failed");
    end
    $finish;
  end

  // Predict on each accepted command and check each result beat
  initial begin
    shadow_count = 0;
    fail_count   = 0;
  end

  always @(posedge clk) begin
    sched_beat_t got;
    sched_beat_t want;
    if (rst_n && start && !busy) begin
      run_table_command(drive_cmd);
      // a typed row replaces the predicted status with the one read off by hand
      if (drive_typed) begin
        void'(outstanding_results.pop_back());
        outstanding_results.push_back(status_only(drive_code));
      end
    end
    if (rst_n && out_valid) begin
      got = '{out_kind, out_status, out_tx_id, out_tx_extended, out_tx_remote,
              out_tx_length, out_tx_slot, out_last};
      if (outstanding_results.size() == 0) begin
        $display("%0t: result beat with none pending: kind=%0d status=%0d id=%h last=%0d",
                 $time, got.kind, got.status, got.tx_id, got.last);
        fail_count++;
      end else begin
        want = outstanding_results.pop_front();
        if (got !== want) begin
          $display("%0t: result mismatch expected kind=%0d status=%0d id=%h ext=%0d rtr=%0d",
                   $time, want.kind, want.status, want.tx_id, want.tx_ext, want.tx_rtr);
          $display("  len=%0d slot=%0d last=%0d; actual kind=%0d status=%0d id=%h ext=%0d",
                   want.tx_len, want.tx_slot, want.last, got.kind, got.status, got.tx_id,
                   got.tx_ext);
          $display("  rtr=%0d len=%0d slot=%0d last=%0d",
                   got.tx_rtr, got.tx_len, got.tx_slot, got.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run after too many cycles with no beat moving
  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("periodic_message_scheduler test failed");
      $finish;
    end
  end

endmodule
